// ===== rtl/sk384_pkg.sv =====
// ----------------------------------------------------------------------------
// sk384_pkg
// Shared types, constant tables and round-constant helpers for the
// SKINNY-128-384 encryption pipeline.
// ----------------------------------------------------------------------------
package sk384_pkg;

	// Sixteen byte cells; cell 0 is the most significant byte.
	typedef logic [0:15][7:0] cells_t;

	// Default round count for SKINNY-128-384.
	localparam int unsigned ROUNDS_DEF = 56;

	localparam logic [7:0] TK_XOR_CONST = 8'h02;
	localparam logic [3:0] RC_LO_MASK   = 4'hf;

	localparam logic [7:0] SBOX [256] = '{
		8'h65,8'h4c,8'h6a,8'h42,8'h4b,8'h63,8'h43,8'h6b,
		8'h55,8'h75,8'h5a,8'h7a,8'h53,8'h73,8'h5b,8'h7b,
		8'h35,8'h8c,8'h3a,8'h81,8'h89,8'h33,8'h80,8'h3b,
		8'h95,8'h25,8'h98,8'h2a,8'h90,8'h23,8'h99,8'h2b,
		8'he5,8'hcc,8'he8,8'hc1,8'hc9,8'he0,8'hc0,8'he9,
		8'hd5,8'hf5,8'hd8,8'hf8,8'hd0,8'hf0,8'hd9,8'hf9,
		8'ha5,8'h1c,8'ha8,8'h12,8'h1b,8'ha0,8'h13,8'ha9,
		8'h05,8'hb5,8'h0a,8'hb8,8'h03,8'hb0,8'h0b,8'hb9,
		8'h32,8'h88,8'h3c,8'h85,8'h8d,8'h34,8'h84,8'h3d,
		8'h91,8'h22,8'h9c,8'h2c,8'h94,8'h24,8'h9d,8'h2d,
		8'h62,8'h4a,8'h6c,8'h45,8'h4d,8'h64,8'h44,8'h6d,
		8'h52,8'h72,8'h5c,8'h7c,8'h54,8'h74,8'h5d,8'h7d,
		8'ha1,8'h1a,8'hac,8'h15,8'h1d,8'ha4,8'h14,8'had,
		8'h02,8'hb1,8'h0c,8'hbc,8'h04,8'hb4,8'h0d,8'hbd,
		8'he1,8'hc8,8'hec,8'hc5,8'hcd,8'he4,8'hc4,8'hed,
		8'hd1,8'hf1,8'hdc,8'hfc,8'hd4,8'hf4,8'hdd,8'hfd,
		8'h36,8'h8e,8'h38,8'h82,8'h8b,8'h30,8'h83,8'h39,
		8'h96,8'h26,8'h9a,8'h28,8'h93,8'h20,8'h9b,8'h29,
		8'h66,8'h4e,8'h68,8'h41,8'h49,8'h60,8'h40,8'h69,
		8'h56,8'h76,8'h58,8'h78,8'h50,8'h70,8'h59,8'h79,
		8'ha6,8'h1e,8'haa,8'h11,8'h19,8'ha3,8'h10,8'hab,
		8'h06,8'hb6,8'h08,8'hba,8'h00,8'hb3,8'h09,8'hbb,
		8'he6,8'hce,8'hea,8'hc2,8'hcb,8'he3,8'hc3,8'heb,
		8'hd6,8'hf6,8'hda,8'hfa,8'hd3,8'hf3,8'hdb,8'hfb,
		8'h31,8'h8a,8'h3e,8'h86,8'h8f,8'h37,8'h87,8'h3f,
		8'h92,8'h21,8'h9e,8'h2e,8'h97,8'h27,8'h9f,8'h2f,
		8'h61,8'h48,8'h6e,8'h46,8'h4f,8'h67,8'h47,8'h6f,
		8'h51,8'h71,8'h5e,8'h7e,8'h57,8'h77,8'h5f,8'h7f,
		8'ha2,8'h18,8'hae,8'h16,8'h1f,8'ha7,8'h17,8'haf,
		8'h01,8'hb2,8'h0e,8'hbe,8'h07,8'hb7,8'h0f,8'hbf,
		8'he2,8'hca,8'hee,8'hc6,8'hcf,8'he7,8'hc7,8'hef,
		8'hd2,8'hf2,8'hde,8'hfe,8'hd7,8'hf7,8'hdf,8'hff
	};

	// Tweakey cell permutation and ShiftRows as gather maps.
	localparam logic [3:0] TK_PERM [16] = '{
		4'd9, 4'd15, 4'd8, 4'd13, 4'd10, 4'd14, 4'd12, 4'd11,
		4'd0, 4'd1,  4'd2, 4'd3,  4'd4,  4'd5,  4'd6,  4'd7
	};
	localparam logic [3:0] ROW_ROT [16] = '{
		4'd0,  4'd1,  4'd2,  4'd3,  4'd7,  4'd4,  4'd5,  4'd6,
		4'd10, 4'd11, 4'd8,  4'd9,  4'd13, 4'd14, 4'd15, 4'd12
	};

	// One step of the 6-bit round-constant LFSR.
	function automatic logic [5:0] rc_next(input logic [5:0] rc);
		rc_next = {rc[4:0], rc[5] ^ rc[4] ^ 1'b1};
	endfunction

	// Constant used in round r (counted from 0); evaluated at elaboration.
	function automatic logic [5:0] rc_for_round(input int unsigned r);
		logic [5:0] rc;
		rc = 6'd0;
		for (int unsigned k = 0; k <= r; k++) begin
			rc = rc_next(rc);
		end
		rc_for_round = rc;
	endfunction

endpackage

// ===== rtl/skinny_128_384_encrypt.sv =====
// ----------------------------------------------------------------------------
// skinny_128_384_encrypt
// Fully unrolled SKINNY-128-384 encryption, one pipeline stage per round.
// ----------------------------------------------------------------------------
// A new word is taken at every clock edge where start is high; busy is always
// low because the pipeline never stalls. The ciphertext appears on cipher_hi
// and cipher_lo, marked by done for exactly one cycle, after the word has
// passed the chain of ROUNDS round stages, each a full round plus one tweakey
// schedule step between registers. The receiver cannot stall the output, so
// it must take every result in the cycle that done is high. Words leave in
// the order they came in, and one word per cycle is sustained.
module skinny_128_384_encrypt #(
	parameter int unsigned ROUNDS = sk384_pkg::ROUNDS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [63:0] plain_hi,
	input  logic [63:0] plain_lo,
	input  logic [63:0] tweakey_w0,
	input  logic [63:0] tweakey_w1,
	input  logic [63:0] tweakey_w2,
	input  logic [63:0] tweakey_w3,
	input  logic [63:0] tweakey_w4,
	input  logic [63:0] tweakey_w5,
	output logic        done,
	output logic [63:0] cipher_hi,
	output logic [63:0] cipher_lo
);

	// Stage r of these chains feeds round r; the last entry is the result.
	logic              vld [ROUNDS + 1];
	sk384_pkg::cells_t st  [ROUNDS + 1];
	sk384_pkg::cells_t tk1 [ROUNDS + 1];
	sk384_pkg::cells_t tk2 [ROUNDS + 1];
	sk384_pkg::cells_t tk3 [ROUNDS + 1];

	// The pipeline always has room, so a start is accepted unconditionally.
	assign busy = 1'b0;

	// The packed cell type puts cell 0 in the top byte, matching the
	// big-endian port packing.
	assign vld[0] = start;
	assign st[0]  = {plain_hi, plain_lo};
	assign tk1[0] = {tweakey_w0, tweakey_w1};
	assign tk2[0] = {tweakey_w2, tweakey_w3};
	assign tk3[0] = {tweakey_w4, tweakey_w5};

	// Each round gets its round constant folded in as a parameter, so the
	// constant LFSR costs no logic.
	for (genvar r = 0; r < ROUNDS; r++) begin : g_round
		sk384_round #(
			.RC(sk384_pkg::rc_for_round(r))
		) u_round (
			.clk    (clk),
			.arst_n (arst_n),
			.vld_in (vld[r]),
			.st_in  (st[r]),
			.tk1_in (tk1[r]),
			.tk2_in (tk2[r]),
			.tk3_in (tk3[r]),
			.vld_s1 (vld[r + 1]),
			.st_s1  (st[r + 1]),
			.tk1_s1 (tk1[r + 1]),
			.tk2_s1 (tk2[r + 1]),
			.tk3_s1 (tk3[r + 1])
		);
	end

	// The last stage register is the output register; the final tweakey
	// state is not needed and is left for synthesis to trim.
	assign done      = vld[ROUNDS];
	assign cipher_hi = st[ROUNDS][0:7];
	assign cipher_lo = st[ROUNDS][8:15];

endmodule

// ===== rtl/sk384_round.sv =====
// ----------------------------------------------------------------------------
// sk384_round
// One registered SKINNY-128-384 round: state update and tweakey schedule step.
// ----------------------------------------------------------------------------
module sk384_round #(
	parameter logic [5:0] RC = 6'd1
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 vld_in,
	input  sk384_pkg::cells_t    st_in,
	input  sk384_pkg::cells_t    tk1_in,
	input  sk384_pkg::cells_t    tk2_in,
	input  sk384_pkg::cells_t    tk3_in,
	output logic                 vld_s1,
	output sk384_pkg::cells_t    st_s1,
	output sk384_pkg::cells_t    tk1_s1,
	output sk384_pkg::cells_t    tk2_s1,
	output sk384_pkg::cells_t    tk3_s1
);

	sk384_pkg::cells_t sb, sr, mc, p1, p2, p3;

	always_comb begin
		for (int i = 0; i < 16; i++) begin
			sb[i] = sk384_pkg::SBOX[st_in[i]];
		end
		sb[0] = sb[0] ^ {4'd0, RC[3:0] & sk384_pkg::RC_LO_MASK};
		sb[4] = sb[4] ^ {6'd0, RC[5:4]};
		sb[8] = sb[8] ^ sk384_pkg::TK_XOR_CONST;
		for (int i = 0; i < 8; i++) begin
			sb[i] = sb[i] ^ tk1_in[i] ^ tk2_in[i] ^ tk3_in[i];
		end
		for (int i = 0; i < 16; i++) begin
			sr[i] = sb[sk384_pkg::ROW_ROT[i]];
		end
		// MixColumns of SKINNY: binary matrix, XORs only.
		for (int c = 0; c < 4; c++) begin
			mc[c]      = sr[c] ^ sr[8 + c] ^ sr[12 + c];
			mc[4 + c]  = sr[c];
			mc[8 + c]  = sr[4 + c] ^ sr[8 + c];
			mc[12 + c] = sr[c] ^ sr[8 + c];
		end
		for (int i = 0; i < 16; i++) begin
			p1[i] = tk1_in[sk384_pkg::TK_PERM[i]];
			p2[i] = tk2_in[sk384_pkg::TK_PERM[i]];
			p3[i] = tk3_in[sk384_pkg::TK_PERM[i]];
		end
		// The LFSRs step only the two top rows.
		for (int i = 0; i < 8; i++) begin
			p2[i] = {p2[i][6:0], p2[i][7] ^ p2[i][5]};
			p3[i] = {p3[i][0] ^ p3[i][6], p3[i][7:1]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		st_s1  <= mc;
		tk1_s1 <= p1;
		tk2_s1 <= p2;
		tk3_s1 <= p3;
	end

endmodule

// ===== rtl/sk384_checker.sv =====
// ----------------------------------------------------------------------------
// sk384_checker
// Port-level checks of the SKINNY-128-384 pipeline: busy never raised, latency
// and determinism of results.
// ----------------------------------------------------------------------------
module sk384_checker #(
	parameter int unsigned ROUNDS = sk384_pkg::ROUNDS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	input logic        start,
	input logic        busy,
	input logic [63:0] plain_hi,
	input logic [63:0] plain_lo,
	input logic [63:0] tweakey_w0,
	input logic [63:0] tweakey_w1,
	input logic [63:0] tweakey_w2,
	input logic [63:0] tweakey_w3,
	input logic [63:0] tweakey_w4,
	input logic [63:0] tweakey_w5,
	input logic        done,
	input logic [63:0] cipher_hi,
	input logic [63:0] cipher_lo
);

	localparam int unsigned AGE_MAX = ROUNDS + 2;
	localparam int unsigned AGE_W   = $clog2(AGE_MAX + 1);

	logic [AGE_W-1:0] age_q;
	logic             warm;
	logic             same_in;
	logic [511:0]     in_now;
	logic [511:0]     in_q;

	// Counts cycles since reset so that history lookups never reach into it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			age_q <= '0;
		end else if (age_q != AGE_W'(AGE_MAX)) begin
			age_q <= age_q + 1'b1;
		end
	end

	assign warm = (age_q == AGE_W'(AGE_MAX));

	// The input word of the previous cycle, kept to spot repeated words.
	assign in_now = {plain_hi, plain_lo, tweakey_w0, tweakey_w1,
		tweakey_w2, tweakey_w3, tweakey_w4, tweakey_w5};

	always_ff @(posedge clk) begin
		in_q <= in_now;
	end

	assign same_in = (in_now == in_q);

	a_never_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!busy)
		else $error("busy raised although the pipeline never stalls");

	a_done_has_source: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done |-> $past(start && !busy, ROUNDS))
		else $error("result without an accepted word ROUNDS cycles earlier");

	a_word_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		warm && $past(start && !busy, ROUNDS) |-> done)
		else $error("accepted word produced no result after ROUNDS cycles");

	a_deterministic: assert property (@(posedge clk) disable iff (!arst_n)
		warm && done && $past(done) && $past(same_in, ROUNDS)
		|-> $stable(cipher_hi) && $stable(cipher_lo))
		else $error("identical back-to-back words gave different ciphertexts");

endmodule

bind skinny_128_384_encrypt sk384_checker #(.ROUNDS(ROUNDS)) u_sk384_checker (.*);
